>>> design/skc_pkg.sv
package skc_pkg;

    // Field widths of the two channels and of the configuration port.
    localparam int BASE_W     = 2;
    localparam int CODE_W     = 16;
    localparam int COUNT_W    = 24;
    localparam int KLEN_W     = 4;
    localparam int SKIP_W     = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    // Register reset values.
    localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(4);
    localparam logic [SKIP_W-1:0] SKIP_RESET = '0;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_KMER_LENGTH = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_SKIP_COUNT  = CFG_ADDR_W'(1);

    // Operation codes of an input beat.
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

endpackage

>>> design/skc_in_if.sv
interface skc_in_if;
    import skc_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [BASE_W-1:0] base;

    modport source (output valid, output operation, output base, input ready);
    modport sink   (input valid, input operation, input base, output ready);
endinterface

>>> design/skc_out_if.sv
interface skc_out_if;
    import skc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  kmer_code;
    logic [COUNT_W-1:0] kmer_count;
    logic               found;

    modport source (output valid, output kmer_code, output kmer_count, output found,
                    input ready);
    modport sink   (input valid, input kmer_code, input kmer_count, input found,
                    output ready);
endinterface

>>> design/skc_count_ram.sv
module skc_count_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Read-first: a read and a write of the same entry in one cycle return the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/skc_kmer_window.sv
module skc_kmer_window #(
    parameter int MAX_KMER_LENGTH = 8,
    parameter int MAX_SKIP        = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [skc_pkg::BASE_W-1:0]     i_base,
    input  logic                           i_clear,
    input  logic [$clog2(MAX_KMER_LENGTH+1)-1:0] i_k,
    input  logic [$clog2(MAX_SKIP+2)-1:0]  i_step,
    output logic                           o_valid,
    output logic [2*MAX_KMER_LENGTH-1:0]   o_code
);
    import skc_pkg::*;

    localparam int HIST_DEPTH = (MAX_SKIP + 1) * (MAX_KMER_LENGTH - 1) + 1;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int HIDX_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CODE_BITS  = 2 * MAX_KMER_LENGTH;

    logic [BASE_W-1:0]    r_hist [HIST_DEPTH];
    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    n_fill;
    logic [FILL_W-1:0]    win_len;
    logic                 r_valid;
    logic [CODE_BITS-1:0] code;

    assign win_len = FILL_W'(int'(i_step) * (int'(i_k) - 1) + 1);

    always_comb begin
        n_fill = r_fill;
        if (i_push && (int'(r_fill) < HIST_DEPTH)) begin
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_push && (n_fill >= win_len);
            if (i_clear) begin
                r_fill <= '0;
            end else begin
                r_fill <= n_fill;
            end
        end
    end

    // The history needs no reset: the fill count keeps stale bases out of every k-mer.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_hist[0] <= i_base;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // Digit d (counted from the least significant end) is the base d*step places back.
    always_comb begin
        int pos;
        code = '0;
        for (int d = 0; d < MAX_KMER_LENGTH; d++) begin
            pos = d * int'(i_step);
            if (pos > HIST_DEPTH - 1) begin
                pos = HIST_DEPTH - 1;
            end
            if (d < int'(i_k)) begin
                code[2*d +: 2] = r_hist[HIDX_W'(pos)];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_code  = code;

endmodule

>>> design/spaced_kmer_counter.sv
// Gapped k-mer histogram over a stream of 2-bit DNA bases (A=0, C=1, G=2, T=3).
// Input channel i_in carries one beat per operation: a push of one base or a
// drain request. A push gives no result beat; a drain gives exactly one on o_out.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data, and the
// user must write it only while the block is idle; the block does not enforce
// this. Register 0 is the k-mer length, register 1 the skip count. After reset
// the count memory is cleared one entry per cycle, all 2**(2*MAX_KMER_LENGTH)
// entries (65536 with the defaults); i_in.ready stays low during that pass,
// configuration writes are taken as ever. Pushes stream at one base per cycle
// while no clearing pass or drain is under way. Each counted k-mer goes through
// a read-modify-write of the count memory once it has passed the window's valid
// register and the update register; a forwarding register covers back-to-back
// updates of the same code. A drain waits for those updates to land, then reads
// the memory one entry per cycle upward from the drain pointer; up to
// 2**(2*MAX_KMER_LENGTH) entries are scanned, and the result register is loaded
// when the scan ends. The scan rate is set by the single read port of the count
// memory. The result sits in an output register; pushes keep being taken while it
// waits, and a further drain finishes only once the receiver has taken it.
// A drain that finds nothing reports found=0 and starts a new sequence.
module spaced_kmer_counter #(
    parameter int MAX_KMER_LENGTH = 8,
    parameter int MAX_SKIP        = 7,
    parameter int COUNT_BITS      = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [skc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [skc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    skc_in_if.sink                           i_in,
    skc_out_if.source                        o_out
);
    import skc_pkg::*;

    localparam int KW        = $clog2(MAX_KMER_LENGTH + 1);
    localparam int SW        = $clog2(MAX_SKIP + 2);
    localparam int CODE_BITS = 2 * MAX_KMER_LENGTH;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_RUN,
        S_SCAN,
        S_EMIT
    } t_state;

    // Configuration registers and their clamped values.
    logic [KLEN_W-1:0] r_kmer_length;
    logic [SKIP_W-1:0] r_skip_count;
    logic [KW-1:0]     k_eff;
    logic [SW-1:0]     step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= KLEN_RESET;
            r_skip_count  <= SKIP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_KMER_LENGTH: r_kmer_length <= i_cfg_data[KLEN_W-1:0];
                CFG_SKIP_COUNT:  r_skip_count  <= i_cfg_data[SKIP_W-1:0];
            endcase
        end
    end

    // A length of zero acts as one; values beyond the supported maximum are clamped.
    always_comb begin
        if (r_kmer_length == '0) begin
            k_eff = KW'(1);
        end else if (int'(r_kmer_length) > MAX_KMER_LENGTH) begin
            k_eff = KW'(MAX_KMER_LENGTH);
        end else begin
            k_eff = KW'(r_kmer_length);
        end
        if (int'(r_skip_count) > MAX_SKIP) begin
            step = SW'(MAX_SKIP + 1);
        end else begin
            step = SW'(int'(r_skip_count) + 1);
        end
    end

    // Input handshake.
    t_state r_state;
    logic   in_acc;
    logic   push_acc;
    logic   drain_acc;

    assign i_in.ready = (r_state == S_RUN);
    assign in_acc     = i_in.valid && i_in.ready;
    assign push_acc   = in_acc && (i_in.operation == OP_PUSH);
    assign drain_acc  = in_acc && (i_in.operation == OP_DRAIN);

    // Base history and k-mer extraction. Its output is the read stage of the update.
    logic                 win_valid;
    logic [CODE_BITS-1:0] win_code;
    logic                 scan_miss;

    skc_kmer_window #(
        .MAX_KMER_LENGTH (MAX_KMER_LENGTH),
        .MAX_SKIP        (MAX_SKIP)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_acc),
        .i_base  (i_in.base),
        .i_clear (scan_miss),
        .i_k     (k_eff),
        .i_step  (step),
        .o_valid (win_valid),
        .o_code  (win_code)
    );

    // Count memory.
    logic                  ram_we;
    logic [CODE_BITS-1:0]  ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [CODE_BITS-1:0]  ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    skc_count_ram #(
        .ADDR_W (CODE_BITS),
        .DATA_W (COUNT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Update stage: the read data arrives, the count is bumped and written back.
    // The entry written in the previous cycle is forwarded, since its read was
    // issued in the same cycle as that write and returned the old value.
    logic                  r_b_valid;
    logic [CODE_BITS-1:0]  r_b_code;
    logic                  r_c_valid;
    logic [CODE_BITS-1:0]  r_c_code;
    logic [COUNT_BITS-1:0] r_c_data;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;

    always_comb begin
        if (r_c_valid && (r_c_code == r_b_code)) begin
            cur_count = r_c_data;
        end else begin
            cur_count = ram_rdata;
        end
        if (cur_count == '1) begin
            inc_count = cur_count;
        end else begin
            inc_count = cur_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= win_valid;
            r_c_valid <= r_b_valid;
        end
        r_b_code <= win_code;
        r_c_code <= r_b_code;
        r_c_data <= inc_count;
    end

    // Drain scan and result registers.
    logic [CODE_BITS-1:0]  r_clr_addr;
    logic [CODE_BITS-1:0]  r_ptr;
    logic                  r_scan_rd;
    logic [CODE_BITS-1:0]  r_scan_addr;
    logic                  r_res_found;
    logic [CODE_BITS-1:0]  r_res_code;
    logic [COUNT_BITS-1:0] r_res_count;
    logic                  r_out_valid;
    logic [CODE_W-1:0]     r_out_code;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_found;
    logic                  scan_go;
    logic                  scan_hit;

    // The first scan read waits until every pending count update has been written.
    assign scan_go   = (r_state == S_SCAN) && !r_scan_rd && !win_valid && !r_b_valid;
    assign scan_hit  = (r_state == S_SCAN) && r_scan_rd && (ram_rdata != '0);
    assign scan_miss = (r_state == S_SCAN) && r_scan_rd && (ram_rdata == '0)
                       && (r_scan_addr == '1);

    always_comb begin
        if (r_state == S_SCAN) begin
            if (r_scan_rd) begin
                ram_raddr = r_scan_addr + 1'b1;
            end else begin
                ram_raddr = r_ptr;
            end
        end else begin
            ram_raddr = win_code;
        end
    end

    // The three writers never overlap: the clearing pass, the drain that zeroes a
    // returned entry, and the count update.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_b_code;
        ram_wdata = inc_count;
        priority if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (scan_hit) begin
            ram_we    = 1'b1;
            ram_waddr = r_scan_addr;
            ram_wdata = '0;
        end else if (r_b_valid) begin
            ram_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_ptr       <= '0;
            r_scan_rd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In the emit state the result register is reloaded below instead.
            if (r_out_valid && o_out.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (drain_acc) begin
                        r_scan_rd <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_go) begin
                        r_scan_rd   <= 1'b1;
                        r_scan_addr <= r_ptr;
                    end else if (scan_hit) begin
                        r_res_found <= 1'b1;
                        r_res_code  <= r_scan_addr;
                        r_res_count <= ram_rdata;
                        r_ptr       <= r_scan_addr + 1'b1;
                        r_scan_rd   <= 1'b0;
                        r_state     <= S_EMIT;
                    end else if (scan_miss) begin
                        r_res_found <= 1'b0;
                        r_res_code  <= '0;
                        r_res_count <= '0;
                        r_ptr       <= '0;
                        r_scan_rd   <= 1'b0;
                        r_state     <= S_EMIT;
                    end else if (r_scan_rd) begin
                        r_scan_addr <= r_scan_addr + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_res_found;
                        r_out_code  <= CODE_W'(r_res_code);
                        r_out_count <= COUNT_W'(r_res_count);
                        r_state     <= S_RUN;
                    end
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kmer_code  = r_out_code;
    assign o_out.kmer_count = r_out_count;
    assign o_out.found      = r_out_found;

    // Only one writer drives the count memory in any cycle.
    a_single_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({(r_state == S_CLEAR), scan_hit, r_b_valid}))
        else $error("count memory write port driven by more than one source");

    // A returned entry always carries a non-zero count.
    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_res_found) |-> (r_res_count != '0))
        else $error("drain returned an empty entry");

    // An empty scan reports a zero code and count.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_res_found) |-> (r_res_code == '0 && r_res_count == '0))
        else $error("not-found result carries data");

    // An accepted drain starts a fresh scan with no read in flight.
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_acc |=> (r_state == S_SCAN && !r_scan_rd))
        else $error("drain did not start a fresh scan");

    // No count update is in flight while the memory is being cleared.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!win_valid && !r_b_valid))
        else $error("count update during clearing pass");

endmodule
